// File: sv/ocp_pkg.sv
// Shared types and constants for the orbit camera position block.
// Holds field widths, register indexes, reset values and the controller and datapath
// command and status structs. Depends on nothing.
package ocp_pkg;

    // Field widths.
    localparam int RADIUS_W   = 15;
    localparam int ANGLE_W    = 16;
    localparam int STEP_W     = 8;
    localparam int ZOOM_W     = 13;
    localparam int EYE_W      = 16;
    localparam int SINE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default values of the top-level parameters.
    localparam int SINE_QUARTER_ENTRIES_DEF = 1024;
    localparam int MIN_RADIUS_DEF           = 128;
    localparam int MAX_RADIUS_DEF           = 17920;

    // Reset values of the configuration registers and the camera state.
    localparam logic [RADIUS_W-1:0] INITIAL_RADIUS_RST    = 15'd2560;
    localparam logic [ANGLE_W-1:0]  INITIAL_ELEVATION_RST = 16'd16384;
    localparam logic [ANGLE_W-1:0]  INITIAL_AZIMUTH_RST   = 16'd0;
    localparam logic [ANGLE_W-1:0]  ANGLE_STEP_RST        = 16'd182;

    // A quarter turn in binary angle units; cosine is sine a quarter turn ahead.
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

    // Pi in unsigned Q4.60 and the Taylor series divisors (2n)(2n+1), n = 1..14.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam int TAYLOR_TERMS = 14;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_RADIUS    = 2'd0,
        CFG_INITIAL_ELEVATION = 2'd1,
        CFG_INITIAL_AZIMUTH   = 2'd2,
        CFG_ANGLE_STEP        = 2'd3
    } t_cfg_idx;

    // Which angle drives the sine table address.
    typedef enum logic [1:0] {
        ROM_SIN_EL = 2'd0,
        ROM_COS_EL = 2'd1,
        ROM_SIN_AZ = 2'd2,
        ROM_COS_AZ = 2'd3
    } t_rom_sel;

    // Which work register takes the scaled product.
    typedef enum logic [1:0] {
        DEST_NONE = 2'd0,
        DEST_RS   = 2'd1,
        DEST_Y    = 2'd2,
        DEST_X    = 2'd3
    } t_dest;

    // Controller commands to the datapath.
    typedef struct packed {
        logic     load;       // transaction accepted: update radius and angles
        t_rom_sel rom_sel;    // angle for the table read this cycle
        logic     mul_en;     // load the product register
        logic     mul_use_rs; // multiply by R*sin(el) instead of R
        t_dest    dest;       // capture of the scaled product
        logic     cap_up;     // capture the sign of sin(el)
        logic     out_load;   // move the finished result to the output stage
    } t_ocp_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic out_free;       // output stage can take a result this cycle
    } t_ocp_sts;

endpackage

// File: sv/ocp_sine_rom.sv
// Quarter-wave sine table with a registered read port.
// The contents are computed at elaboration with a fixed-point Taylor series.
// Depends on ocp_pkg.
module ocp_sine_rom #(
    parameter int SINE_QUARTER_ENTRIES = ocp_pkg::SINE_QUARTER_ENTRIES_DEF,
    parameter int ADDR_W               = $clog2(SINE_QUARTER_ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic [ADDR_W-1:0]           i_addr,
    output logic [ocp_pkg::SINE_W-1:0]  o_data
);
    import ocp_pkg::*;

    typedef logic [SINE_W-1:0] t_rom [0:SINE_QUARTER_ENTRIES];

    // Unsigned Q60 product, (a*b) >> 60.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Entry k holds round(32767*sin(pi/2 * k/SINE_QUARTER_ENTRIES)).
    function automatic t_rom build_table();
        t_rom        tab;
        logic [63:0] half_pi;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        half_pi = PI_Q60 >> 1;
        for (int k = 0; k <= SINE_QUARTER_ENTRIES; k++) begin
            x = (half_pi / SINE_QUARTER_ENTRIES) * 64'(k)
                + ((half_pi % SINE_QUARTER_ENTRIES) * 64'(k)) / SINE_QUARTER_ENTRIES;
            x2   = mul_q60(x, x);
            term = x;
            sum  = x;
            for (int n = 0; n < TAYLOR_TERMS; n++) begin
                term = mul_q60(term, x2) / TAYLOR_DIV[n];
                if (n[0] == 1'b0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            scaled = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
            tab[k] = scaled[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_table();

    // Registered read.
    always_ff @(posedge i_clk) begin
        o_data <= SINE_ROM[i_addr];
    end

endmodule

// File: sv/ocp_datapath.sv
// Datapath of the orbit camera: configuration registers, camera state, table
// addressing, the shared multiplier and the output stage.
// Depends on ocp_pkg and ocp_sine_rom.
module ocp_datapath #(
    parameter int SINE_QUARTER_ENTRIES = ocp_pkg::SINE_QUARTER_ENTRIES_DEF,
    parameter int MIN_RADIUS           = ocp_pkg::MIN_RADIUS_DEF,
    parameter int MAX_RADIUS           = ocp_pkg::MAX_RADIUS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ocp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ocp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_restart,
    input  logic signed [ocp_pkg::STEP_W-1:0]   i_vert_steps,
    input  logic signed [ocp_pkg::STEP_W-1:0]   i_horiz_steps,
    input  logic signed [ocp_pkg::ZOOM_W-1:0]   i_zoom_delta,
    input  ocp_pkg::t_ocp_cmd                   i_cmd,
    output ocp_pkg::t_ocp_sts                   o_sts,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [ocp_pkg::EYE_W-1:0]    o_eye_x,
    output logic signed [ocp_pkg::EYE_W-1:0]    o_eye_y,
    output logic signed [ocp_pkg::EYE_W-1:0]    o_eye_z,
    output logic                                o_up_positive
);
    import ocp_pkg::*;

    localparam int PHASES  = 4 * SINE_QUARTER_ENTRIES;
    localparam int IDX_W   = $clog2(PHASES);
    localparam int ADDR_W  = $clog2(SINE_QUARTER_ENTRIES + 1);
    localparam int SCALE_W = ANGLE_W + IDX_W;
    localparam int RSUM_W  = RADIUS_W + 2;
    localparam int PROD_W  = 2 * SINE_W;

    localparam logic [IDX_W-1:0] Q1 = IDX_W'(SINE_QUARTER_ENTRIES);
    localparam logic [IDX_W-1:0] Q2 = IDX_W'(2 * SINE_QUARTER_ENTRIES);
    localparam logic [IDX_W-1:0] Q3 = IDX_W'(3 * SINE_QUARTER_ENTRIES);
    localparam logic [RADIUS_W-1:0] RMIN = RADIUS_W'(MIN_RADIUS);
    localparam logic [RADIUS_W-1:0] RMAX = RADIUS_W'(MAX_RADIUS);
    localparam logic signed [RSUM_W-1:0] RMIN_S = RSUM_W'(MIN_RADIUS);
    localparam logic signed [RSUM_W-1:0] RMAX_S = RSUM_W'(MAX_RADIUS);

    // Configuration registers.
    logic [RADIUS_W-1:0] r_init_radius;
    logic [ANGLE_W-1:0]  r_init_elevation;
    logic [ANGLE_W-1:0]  r_init_azimuth;
    logic [ANGLE_W-1:0]  r_angle_step;

    // Camera state.
    logic [RADIUS_W-1:0] r_radius;
    logic [ANGLE_W-1:0]  r_elevation;
    logic [ANGLE_W-1:0]  r_azimuth;
    logic [RADIUS_W-1:0] n_radius;
    logic [ANGLE_W-1:0]  n_elevation;
    logic [ANGLE_W-1:0]  n_azimuth;

    // Work registers.
    logic                     r_rom_neg;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [EYE_W-1:0]  r_rs;
    logic signed [EYE_W-1:0]  r_y;
    logic signed [EYE_W-1:0]  r_x;
    logic                     r_up;

    // Output stage.
    logic                    r_out_valid;
    logic signed [EYE_W-1:0] r_out_x;
    logic signed [EYE_W-1:0] r_out_y;
    logic signed [EYE_W-1:0] r_out_z;
    logic                    r_out_up;

    logic [2*ANGLE_W-1:0]        dv_full;
    logic [2*ANGLE_W-1:0]        dh_full;
    logic signed [RSUM_W-1:0]    rsum;
    logic [ANGLE_W-1:0]          rom_angle;
    logic [SCALE_W-1:0]          phase_scaled;
    logic [IDX_W-1:0]            idx;
    logic [1:0]                  quad;
    logic [IDX_W-1:0]            quad_base;
    logic [IDX_W-1:0]            resid;
    logic [ADDR_W-1:0]           rom_addr;
    logic [SINE_W-1:0]           rom_data;
    logic signed [SINE_W-1:0]    sine_val;
    logic signed [SINE_W-1:0]    mul_a;
    logic signed [EYE_W-1:0]     prod_scaled;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_radius    <= INITIAL_RADIUS_RST;
            r_init_elevation <= INITIAL_ELEVATION_RST;
            r_init_azimuth   <= INITIAL_AZIMUTH_RST;
            r_angle_step     <= ANGLE_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INITIAL_RADIUS:    r_init_radius    <= i_cfg_data[RADIUS_W-1:0];
                CFG_INITIAL_ELEVATION: r_init_elevation <= i_cfg_data[ANGLE_W-1:0];
                CFG_INITIAL_AZIMUTH:   r_init_azimuth   <= i_cfg_data[ANGLE_W-1:0];
                CFG_ANGLE_STEP:        r_angle_step     <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Rotation and zoom; angles wrap modulo one turn, radius saturates.
    always_comb begin
        dv_full = (2*ANGLE_W)'(ANGLE_W'(i_vert_steps)) * (2*ANGLE_W)'(r_angle_step);
        dh_full = (2*ANGLE_W)'(ANGLE_W'(i_horiz_steps)) * (2*ANGLE_W)'(r_angle_step);
        rsum    = $signed({2'b00, r_radius}) + RSUM_W'(i_zoom_delta);
        if (i_restart) begin
            n_elevation = r_init_elevation;
            n_azimuth   = r_init_azimuth;
            if (r_init_radius < RMIN) begin
                n_radius = RMIN;
            end else if (r_init_radius > RMAX) begin
                n_radius = RMAX;
            end else begin
                n_radius = r_init_radius;
            end
        end else begin
            n_elevation = r_elevation + dv_full[ANGLE_W-1:0];
            n_azimuth   = r_azimuth + dh_full[ANGLE_W-1:0];
            if (rsum < RMIN_S) begin
                n_radius = RMIN;
            end else if (rsum > RMAX_S) begin
                n_radius = RMAX;
            end else begin
                n_radius = rsum[RADIUS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= INITIAL_RADIUS_RST;
            r_elevation <= INITIAL_ELEVATION_RST;
            r_azimuth   <= INITIAL_AZIMUTH_RST;
        end else if (i_cmd.load) begin
            r_radius    <= n_radius;
            r_elevation <= n_elevation;
            r_azimuth   <= n_azimuth;
        end
    end

    // Table address: phase index, quadrant, and mirror in odd quadrants.
    always_comb begin
        case (i_cmd.rom_sel)
            ROM_SIN_EL: rom_angle = r_elevation;
            ROM_COS_EL: rom_angle = r_elevation + QUARTER_TURN;
            ROM_SIN_AZ: rom_angle = r_azimuth;
            ROM_COS_AZ: rom_angle = r_azimuth + QUARTER_TURN;
            default:    rom_angle = r_elevation;
        endcase
        phase_scaled = SCALE_W'(rom_angle) * SCALE_W'(PHASES);
        idx          = phase_scaled[SCALE_W-1:ANGLE_W];
        if (idx >= Q3) begin
            quad      = 2'd3;
            quad_base = Q3;
        end else if (idx >= Q2) begin
            quad      = 2'd2;
            quad_base = Q2;
        end else if (idx >= Q1) begin
            quad      = 2'd1;
            quad_base = Q1;
        end else begin
            quad      = 2'd0;
            quad_base = '0;
        end
        resid = idx - quad_base;
        if (quad[0]) begin
            rom_addr = ADDR_W'(Q1 - resid);
        end else begin
            rom_addr = ADDR_W'(resid);
        end
    end

    ocp_sine_rom #(
        .SINE_QUARTER_ENTRIES (SINE_QUARTER_ENTRIES),
        .ADDR_W               (ADDR_W)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // The negate flag travels alongside the registered table read.
    always_ff @(posedge i_clk) begin
        r_rom_neg <= quad[1];
    end

    // Shared multiplier; the product is scaled by 2^-15 with floor.
    always_comb begin
        sine_val    = r_rom_neg ? -$signed(rom_data) : $signed(rom_data);
        mul_a       = i_cmd.mul_use_rs ? r_rs : $signed({1'b0, r_radius});
        prod_scaled = r_prod[EYE_W+14:15];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * sine_val;
        end
        if (i_cmd.cap_up) begin
            r_up <= ~sine_val[SINE_W-1];
        end
        case (i_cmd.dest)
            DEST_RS: r_rs <= prod_scaled;
            DEST_Y:  r_y  <= prod_scaled;
            DEST_X:  r_x  <= prod_scaled;
            default: ;
        endcase
    end

    // Output stage; it frees in the same cycle its transaction completes.
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_x  <= r_x;
            r_out_y  <= r_y;
            r_out_z  <= prod_scaled;
            r_out_up <= r_up;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_eye_x       = r_out_x;
    assign o_eye_y       = r_out_y;
    assign o_eye_z       = r_out_z;
    assign o_up_positive = r_out_up;

endmodule

// File: sv/ocp_ctrl.sv
// Controller of the orbit camera: sequences the four table reads and the four
// products of one transaction, then hands the result to the output stage.
// Depends on ocp_pkg.
module ocp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ocp_pkg::t_ocp_sts  i_sts,
    output ocp_pkg::t_ocp_cmd  o_cmd
);
    import ocp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SIN_EL = 7'b0000010,
        S_COS_EL = 7'b0000100,
        S_SIN_AZ = 7'b0001000,
        S_COS_AZ = 7'b0010000,
        S_MUL_X  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state          = r_state;
        o_cmd.load       = 1'b0;
        o_cmd.rom_sel    = ROM_SIN_EL;
        o_cmd.mul_en     = 1'b0;
        o_cmd.mul_use_rs = 1'b0;
        o_cmd.dest       = DEST_NONE;
        o_cmd.cap_up     = 1'b0;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SIN_EL;
                end
            end
            S_SIN_EL: begin
                o_cmd.rom_sel = ROM_SIN_EL;
                n_state       = S_COS_EL;
            end
            S_COS_EL: begin
                o_cmd.rom_sel = ROM_COS_EL;
                o_cmd.mul_en  = 1'b1;
                o_cmd.cap_up  = 1'b1;
                n_state       = S_SIN_AZ;
            end
            S_SIN_AZ: begin
                o_cmd.rom_sel = ROM_SIN_AZ;
                o_cmd.mul_en  = 1'b1;
                o_cmd.dest    = DEST_RS;
                n_state       = S_COS_AZ;
            end
            S_COS_AZ: begin
                o_cmd.rom_sel    = ROM_COS_AZ;
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_use_rs = 1'b1;
                o_cmd.dest       = DEST_Y;
                n_state          = S_MUL_X;
            end
            S_MUL_X: begin
                o_cmd.rom_sel    = ROM_COS_AZ;
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_use_rs = 1'b1;
                o_cmd.dest       = DEST_X;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    // An accepted transaction steps through S_SIN_EL, S_COS_EL, S_SIN_AZ, S_COS_AZ and S_MUL_X to S_FINISH.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |-> ##6 (r_state == S_FINISH))
        else $error("transaction did not reach the finish step on time");

    // R*sin(el) is captured in the cycle after the elevation sign.
    a_rs_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap_up |=> (o_cmd.dest == DEST_RS))
        else $error("R*sin(el) capture out of order");

    // A finished result waits while the output stage is full.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !i_sts.out_free) |=> (r_state == S_FINISH))
        else $error("result left the finish step while output was full");
`endif

endmodule

// File: sv/orbit_camera_position.sv
// Top level of the orbit camera position block.
// Joins the controller and the datapath. Depends on ocp_pkg, ocp_ctrl and ocp_datapath.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_restart, i_vert_steps, i_horiz_steps,
//                                            i_zoom_delta
//   output   out        o_valid / i_stall    o_eye_x, o_eye_y, o_eye_z, o_up_positive
//   config   in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One transaction passes the accept step, four reads of the single-port sine table,
// the products of the one shared multiplier that trail them, and the finish step.
// The output register lets the block take the next transaction while a result waits.
// Reset is synchronous and active low; it restores the configuration and camera state.
// A stalled output keeps the controller in its finish step until the stage frees.
module orbit_camera_position #(
    parameter int SINE_QUARTER_ENTRIES = ocp_pkg::SINE_QUARTER_ENTRIES_DEF,
    parameter int MIN_RADIUS           = ocp_pkg::MIN_RADIUS_DEF,
    parameter int MAX_RADIUS           = ocp_pkg::MAX_RADIUS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ocp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ocp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_restart,
    input  logic signed [ocp_pkg::STEP_W-1:0]   i_vert_steps,
    input  logic signed [ocp_pkg::STEP_W-1:0]   i_horiz_steps,
    input  logic signed [ocp_pkg::ZOOM_W-1:0]   i_zoom_delta,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ocp_pkg::EYE_W-1:0]    o_eye_x,
    output logic signed [ocp_pkg::EYE_W-1:0]    o_eye_y,
    output logic signed [ocp_pkg::EYE_W-1:0]    o_eye_z,
    output logic                                o_up_positive
);
    import ocp_pkg::*;

    t_ocp_cmd cmd;
    t_ocp_sts sts;

    // Sequencer.
    ocp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Registers, table, multiplier and output stage.
    ocp_datapath #(
        .SINE_QUARTER_ENTRIES (SINE_QUARTER_ENTRIES),
        .MIN_RADIUS           (MIN_RADIUS),
        .MAX_RADIUS           (MAX_RADIUS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_restart     (i_restart),
        .i_vert_steps  (i_vert_steps),
        .i_horiz_steps (i_horiz_steps),
        .i_zoom_delta  (i_zoom_delta),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_eye_x       (o_eye_x),
        .o_eye_y       (o_eye_y),
        .o_eye_z       (o_eye_z),
        .o_up_positive (o_up_positive)
    );

endmodule
